FILE: rtl/core/haversine_distance_core_macros.svh
// Assertion macros shared by the haversine distance core.
`ifndef HAVERSINE_DISTANCE_CORE_MACROS_SVH
`define HAVERSINE_DISTANCE_CORE_MACROS_SVH

// Checks a consequence in the cycle after the antecedent, outside of reset.
`define HDC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Checks what a reset cycle leaves behind.
`define HDC_ASSERT_RESET(lbl, cons, msg) \
   lbl: assert property (@(posedge clock) reset |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/hdc_pkg.sv
// Types and constants of the haversine distance core.
`timescale 1ns / 1ps
package hdc_pkg;

   typedef logic signed [33:0] cordic_type;
   typedef logic signed [32:0] angle_type;
   typedef logic signed [31:0] q30_type;
   typedef logic [61:0] root_type;

   localparam logic signed [30:0] PERIOD = 31'sd377487360;
   localparam logic [29:0] RECIP_45 = 30'd763549741;
   localparam cordic_type INV_GAIN = 34'sd652032874;
   localparam cordic_type ONE_Q30 = 34'sd1073741824;
   localparam logic [31:0] PI_Q30 = 32'd3373259426;
   localparam logic [15:0] RADIUS_RESET = 16'd6371;

   // Fraction of a 45-unit step of reduced angle, in binary-angle units.
   localparam logic [8:0] FULL_TAB [45] = '{
      9'd0,   9'd11,  9'd23,  9'd34,  9'd46,  9'd57,  9'd68,  9'd80,  9'd91,
      9'd102, 9'd114, 9'd125, 9'd137, 9'd148, 9'd159, 9'd171, 9'd182, 9'd193,
      9'd205, 9'd216, 9'd228, 9'd239, 9'd250, 9'd262, 9'd273, 9'd284, 9'd296,
      9'd307, 9'd319, 9'd330, 9'd341, 9'd353, 9'd364, 9'd375, 9'd387, 9'd398,
      9'd410, 9'd421, 9'd432, 9'd444, 9'd455, 9'd466, 9'd478, 9'd489, 9'd501};

   localparam logic [8:0] HALF_TAB [45] = '{
      9'd0,   9'd6,   9'd11,  9'd17,  9'd23,  9'd28,  9'd34,  9'd40,  9'd46,
      9'd51,  9'd57,  9'd63,  9'd68,  9'd74,  9'd80,  9'd85,  9'd91,  9'd97,
      9'd102, 9'd108, 9'd114, 9'd119, 9'd125, 9'd131, 9'd137, 9'd142, 9'd148,
      9'd154, 9'd159, 9'd165, 9'd171, 9'd176, 9'd182, 9'd188, 9'd193, 9'd199,
      9'd205, 9'd210, 9'd216, 9'd222, 9'd228, 9'd233, 9'd239, 9'd245, 9'd250};

   localparam logic [31:0] ATAN_TAB [40] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
      32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
      32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
      32'd20,        32'd10,        32'd5,         32'd3,        32'd1,
      32'd1,         32'd0,         32'd0,         32'd0,        32'd0,
      32'd0,         32'd0,         32'd0,         32'd0,        32'd0};

   function automatic logic [31:0] atan_at(input int i);
      logic [5:0] idx;
      idx = i[5:0];
      return (i < 40) ? ATAN_TAB[idx] : 32'd0;
   endfunction

   function automatic q30_type clamp_q30(input cordic_type v);
      if (v > ONE_Q30) begin
         return ONE_Q30[31:0];
      end else if (v < -ONE_Q30) begin
         return -ONE_Q30[31:0];
      end
      return v[31:0];
   endfunction

endpackage

FILE: rtl/core/haversine_distance_core.sv
// Pipelined haversine great-circle distance core.
`timescale 1ns / 1ps
`include "haversine_distance_core_macros.svh"
// Usage:
// A point pair (latitudes and longitudes in signed degrees times 2^20) is
// offered on the req_ channel and moves on a valid/ready transfer. The
// distance in kilometres times 2^8 leaves on the rsp_ channel the same way.
// The sphere radius in kilometres is written through csr_wr_en and
// csr_wr_data; the user must write it only while the core is idle, which
// the core does not enforce. The radius resets to 6371. The pipeline holds
// two CORDIC chains of CORDIC_STAGES stages and the 31-step square root.
// Throughput is one pair per cycle unless the receiver stalls; every stage
// holds its own item. When the receiver stalls with a result waiting, the
// whole pipeline holds and req_ready drops; nothing is lost or repeated.
// Items keep entering as long as the output register is empty or being drained.
// Reset clears all valid bits and reloads the radius.
module haversine_distance_core
   import hdc_pkg::*;
#(
   parameter int CORDIC_STAGES = 24
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [27:0] req_lat_a,
   input  logic signed [28:0] req_lon_a,
   input  logic signed [27:0] req_lat_b,
   input  logic signed [28:0] req_lon_b,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [25:0]        rsp_distance_q8,
   input  logic               csr_wr_en,
   input  logic [15:0]        csr_wr_data
);

   localparam int N = CORDIC_STAGES;
   localparam int LAT = 44 + 2 * CORDIC_STAGES;
   localparam int ROOT_STEPS = 31;

   logic adv;
   logic [LAT-1:0] vld_ff, vld_in;
   logic [15:0] radius_ff;

   logic signed [27:0] lat_a_ff, lat_b_ff;
   logic signed [28:0] lon_a_ff, lon_b_ff;

   logic [28:0] r_in [4], r_ff [4], r2_ff [4];
   logic [22:0] qe_in [4], qe_ff [4], q_in [4], q_ff [4];
   logic [5:0]  j_in [4], j_ff [4];
   logic [31:0] bam_in [4], bam_ff [4];

   cordic_type cx_in [4][N], cx_ff [4][N], cy_in [4][N], cy_ff [4][N];
   angle_type  cz_in [4][N], cz_ff [4][N];
   logic [1:0] cq_in [4][N], cq_ff [4][N];

   q30_type cos_in [4], cos_ff [4], sin_in [4], sin_ff [4];
   q30_type slat2_in, slat2_ff, slon2_in, slon2_ff, cc_in, cc_ff;
   q30_type p_in, p_ff, slat2b_ff;
   logic [30:0] a_in, a_ff;

   root_type rn_in [2][ROOT_STEPS], rn_ff [2][ROOT_STEPS];
   root_type rr_in [2][ROOT_STEPS], rr_ff [2][ROOT_STEPS];

   cordic_type vx_in [N], vx_ff [N], vy_in [N], vy_ff [N], vz_in [N], vz_ff [N];
   logic [30:0] theta_in, theta_ff;
   logic [47:0] t_in, t_ff;
   logic [63:0] prod_in, prod_ff;
   logic [25:0] dist_in, dist_ff;

   // The pipeline moves as one; it holds only while a result waits.
   assign adv = !vld_ff[LAT-1] || rsp_ready;
   assign req_ready = adv;
   assign vld_in = {vld_ff[LAT-2:0], req_valid};
   assign rsp_valid = vld_ff[LAT-1];
   assign rsp_distance_q8 = dist_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_RESET;
      end else if (csr_wr_en) begin
         radius_ff <= csr_wr_data;
      end
   end

   // Angle reduction into [0, 360) degrees; lanes are lat a, lat b,
   // half latitude difference and half longitude difference.
   always_comb begin
      logic signed [30:0] raw [4];
      logic [58:0] recip;
      logic [28:0] m45;
      logic [28:0] rem;
      raw[0] = 31'(lat_a_ff);
      raw[1] = 31'(lat_b_ff);
      raw[2] = 31'(lat_b_ff) - 31'(lat_a_ff);
      raw[3] = 31'(lon_b_ff) - 31'(lon_a_ff);
      for (int l = 0; l < 4; l++) begin
         if (raw[l] < -PERIOD) begin
            r_in[l] = 29'(raw[l] + (PERIOD <<< 1));
         end else if (raw[l] < 0) begin
            r_in[l] = 29'(raw[l] + PERIOD);
         end else if (raw[l] >= PERIOD) begin
            r_in[l] = 29'(raw[l] - PERIOD);
         end else begin
            r_in[l] = 29'(raw[l]);
         end
         // Quotient by 45 through the reciprocal, low by at most one.
         recip = r_ff[l] * RECIP_45;
         qe_in[l] = recip[57:35];
         m45 = 29'(qe_ff[l] * 6'd45);
         rem = r2_ff[l] - m45;
         if (rem[6:0] >= 7'd45) begin
            q_in[l] = qe_ff[l] + 23'd1;
            j_in[l] = 6'(rem[6:0] - 7'd45);
         end else begin
            q_in[l] = qe_ff[l];
            j_in[l] = rem[5:0];
         end
         if (l < 2) begin
            bam_in[l] = {q_ff[l], 9'd0} + 32'(FULL_TAB[j_ff[l]]);
         end else begin
            bam_in[l] = {1'b0, q_ff[l], 8'd0} + 32'(HALF_TAB[j_ff[l]]);
         end
      end
   end

   // Rotation CORDIC, one stage per register.
   always_comb begin
      cordic_type xs, ys, dx, dy;
      angle_type zs, at;
      logic [1:0] qs;
      for (int l = 0; l < 4; l++) begin
         for (int i = 0; i < N; i++) begin
            if (i == 0) begin
               xs = INV_GAIN;
               ys = '0;
               zs = {3'b000, bam_ff[l][29:0]};
               qs = bam_ff[l][31:30];
            end else begin
               xs = cx_ff[l][i-1];
               ys = cy_ff[l][i-1];
               zs = cz_ff[l][i-1];
               qs = cq_ff[l][i-1];
            end
            dx = ys >>> i;
            dy = xs >>> i;
            at = {1'b0, atan_at(i)};
            if (!zs[32]) begin
               cx_in[l][i] = xs - dx;
               cy_in[l][i] = ys + dy;
               cz_in[l][i] = zs - at;
            end else begin
               cx_in[l][i] = xs + dx;
               cy_in[l][i] = ys - dy;
               cz_in[l][i] = zs + at;
            end
            cq_in[l][i] = qs;
         end
      end
   end

   // Quadrant fold-out and the haversine term.
   always_comb begin
      q30_type xc, yc;
      logic signed [63:0] m_lat, m_lon, m_cc, m_p;
      logic signed [32:0] sum;
      for (int l = 0; l < 4; l++) begin
         xc = clamp_q30(cx_ff[l][N-1]);
         yc = clamp_q30(cy_ff[l][N-1]);
         case (cq_ff[l][N-1])
            2'd0: begin
               cos_in[l] = xc;
               sin_in[l] = yc;
            end
            2'd1: begin
               cos_in[l] = -yc;
               sin_in[l] = xc;
            end
            2'd2: begin
               cos_in[l] = -xc;
               sin_in[l] = -yc;
            end
            default: begin
               cos_in[l] = yc;
               sin_in[l] = -xc;
            end
         endcase
      end
      m_lat = sin_ff[2] * sin_ff[2];
      m_lon = sin_ff[3] * sin_ff[3];
      m_cc = cos_ff[0] * cos_ff[1];
      slat2_in = m_lat[61:30];
      slon2_in = m_lon[61:30];
      cc_in = m_cc[61:30];
      m_p = cc_ff * slon2_ff;
      p_in = m_p[61:30];
      sum = 33'(slat2b_ff) + 33'(p_ff);
      if (sum < 0) begin
         a_in = '0;
      end else if (sum > 33'(ONE_Q30)) begin
         a_in = ONE_Q30[30:0];
      end else begin
         a_in = sum[30:0];
      end
   end

   // Square roots of a and 1 - a, one result bit per stage.
   always_comb begin
      root_type ns, rs, bit_w, trial;
      for (int k = 0; k < 2; k++) begin
         for (int s = 0; s < ROOT_STEPS; s++) begin
            if (s == 0) begin
               if (k == 0) begin
                  ns = {1'b0, a_ff, 30'd0};
               end else begin
                  ns = {1'b0, ONE_Q30[30:0] - a_ff, 30'd0};
               end
               rs = '0;
            end else begin
               ns = rn_ff[k][s-1];
               rs = rr_ff[k][s-1];
            end
            bit_w = 62'd1 << (2 * (ROOT_STEPS - 1 - s));
            trial = rs + bit_w;
            if (ns >= trial) begin
               rn_in[k][s] = ns - trial;
               rr_in[k][s] = (rs >> 1) + bit_w;
            end else begin
               rn_in[k][s] = ns;
               rr_in[k][s] = rs >> 1;
            end
         end
      end
   end

   // Vectoring CORDIC for the central half angle, then scaling.
   always_comb begin
      cordic_type xs, ys, zs, dx, dy, at;
      logic [63:0] scaled, rounded;
      for (int i = 0; i < N; i++) begin
         if (i == 0) begin
            xs = {3'b000, rr_ff[1][ROOT_STEPS-1][30:0]};
            ys = {3'b000, rr_ff[0][ROOT_STEPS-1][30:0]};
            zs = '0;
         end else begin
            xs = vx_ff[i-1];
            ys = vy_ff[i-1];
            zs = vz_ff[i-1];
         end
         dx = ys >>> i;
         dy = xs >>> i;
         at = {2'b00, atan_at(i)};
         if (!ys[33]) begin
            vx_in[i] = xs + dx;
            vy_in[i] = ys - dy;
            vz_in[i] = zs + at;
         end else begin
            vx_in[i] = xs - dx;
            vy_in[i] = ys + dy;
            vz_in[i] = zs - at;
         end
      end
      if (vz_ff[N-1] < 0) begin
         theta_in = '0;
      end else if (vz_ff[N-1] > ONE_Q30) begin
         theta_in = ONE_Q30[30:0];
      end else begin
         theta_in = vz_ff[N-1][30:0];
      end
      scaled = {theta_ff, 1'b0} * PI_Q30;
      t_in = scaled[63:16];
      prod_in = t_ff * radius_ff;
      rounded = prod_ff + (64'd1 << 36);
      dist_in = rounded[62:37];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         lat_a_ff <= req_lat_a;
         lon_a_ff <= req_lon_a;
         lat_b_ff <= req_lat_b;
         lon_b_ff <= req_lon_b;
         for (int l = 0; l < 4; l++) begin
            r_ff[l] <= r_in[l];
            r2_ff[l] <= r_ff[l];
            qe_ff[l] <= qe_in[l];
            q_ff[l] <= q_in[l];
            j_ff[l] <= j_in[l];
            bam_ff[l] <= bam_in[l];
            cos_ff[l] <= cos_in[l];
            sin_ff[l] <= sin_in[l];
            for (int i = 0; i < N; i++) begin
               cx_ff[l][i] <= cx_in[l][i];
               cy_ff[l][i] <= cy_in[l][i];
               cz_ff[l][i] <= cz_in[l][i];
               cq_ff[l][i] <= cq_in[l][i];
            end
         end
         slat2_ff <= slat2_in;
         slon2_ff <= slon2_in;
         cc_ff <= cc_in;
         p_ff <= p_in;
         slat2b_ff <= slat2_ff;
         a_ff <= a_in;
         for (int k = 0; k < 2; k++) begin
            for (int s = 0; s < ROOT_STEPS; s++) begin
               rn_ff[k][s] <= rn_in[k][s];
               rr_ff[k][s] <= rr_in[k][s];
            end
         end
         for (int i = 0; i < N; i++) begin
            vx_ff[i] <= vx_in[i];
            vy_ff[i] <= vy_in[i];
            vz_ff[i] <= vz_in[i];
         end
         theta_ff <= theta_in;
         t_ff <= t_in;
         prod_ff <= prod_in;
         dist_ff <= dist_in;
      end
   end

   `HDC_ASSERT_RESET(a_reset_empties, !rsp_valid, "result valid right after reset")
   `HDC_ASSERT_NEXT(a_stall_freezes, !adv, $stable(vld_ff), "pipeline moved during a stall")
   `HDC_ASSERT_NEXT(a_drain_empty, rsp_valid && rsp_ready && !vld_ff[LAT-2], !rsp_valid, "result invented after drain")

endmodule
